/* src/srcp_pkg.sv */
// shared types and constants for the sector read chunk planner
// no dependencies
`timescale 1ns / 1ps

package srcp_pkg;

    localparam int unsigned SECTOR_BYTES     = 512;
    localparam int unsigned SECTOR_SHIFT     = 9;
    localparam int unsigned DEF_BOUNCE_BYTES = 65536;
    localparam int unsigned DEF_MAX_BLOCKS   = 65535;

    localparam int unsigned LBA_W     = 32;
    localparam int unsigned SPB_W     = 16;
    localparam int unsigned REG_W     = 25;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [REG_W-1:0] BLOCK_SIZE_RST = 25'd512;
    localparam logic [REG_W-1:0] MAX_BULK_RST   = 25'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_READY = 2'd0,
        CFG_BLOCK_SIZE = 2'd1,
        CFG_MAX_BULK   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CHUNK = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERROR = 2'd2,
        ST_IDLE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LINK       = 3'd1,
        ERR_RANGE      = 3'd2,
        ERR_BLOCK_SIZE = 3'd3,
        ERR_ZERO_LIMIT = 3'd4,
        ERR_BOUNCE     = 3'd5
    } err_t;

    typedef struct packed {
        status_t           status;
        err_t              error_code;
        logic [LBA_W-1:0]  phys_block;
        logic [SPB_W-1:0]  block_count;
        logic              bounce;
        logic [14:0]       skip_sectors;
        logic [LBA_W-1:0]  copy_sectors;
        logic [LBA_W-1:0]  dest_sector;
        logic              last;
    } result_t;

endpackage

/* src/srcp_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on srcp_pkg
`timescale 1ns / 1ps

module srcp_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [srcp_pkg::LBA_W-1:0]    dividend,
    input  logic [srcp_pkg::SPB_W-1:0]    divisor,
    output logic                          done,
    output logic [srcp_pkg::LBA_W-1:0]    quotient,
    output logic [srcp_pkg::SPB_W-1:0]    remainder
);

    localparam int unsigned CNT_W = $clog2(srcp_pkg::LBA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(srcp_pkg::LBA_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [srcp_pkg::LBA_W-1:0]  quo_reg, quo_next;
    logic [srcp_pkg::SPB_W-1:0]  rem_reg, rem_next;
    logic [srcp_pkg::SPB_W-1:0]  dvs_reg, dvs_next;

    logic [srcp_pkg::SPB_W:0]    rem_sh;
    logic [srcp_pkg::SPB_W:0]    diff;
    logic                        ge;

    assign rem_sh = {rem_reg, quo_reg[srcp_pkg::LBA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[srcp_pkg::LBA_W-2:0], ge};
            rem_next = ge ? diff[srcp_pkg::SPB_W-1:0] : rem_sh[srcp_pkg::SPB_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* src/sector_read_chunk_planner.sv */
// top level of the sector read chunk planner: sequencer, request state, output register
// depends on srcp_pkg and srcp_divider
`timescale 1ns / 1ps

// Usage
// The s_ channel takes one request word: tuser is the command (start or next),
// tdata holds the first sector and the sector count. Every word accepted gives
// exactly one result word on the m_ channel: tuser is the status, tdata holds the
// error code and the chunk description, tlast marks the end of the request.
// The cfg port writes link ready, block size and bulk limit, one register per
// cycle with no read-back; a start latches the geometry that is in use then.
// One word at a time is processed; s_tready is high only while the sequencer idles.
// All divisions go through one shared divider that gives one quotient bit per
// cycle. A next word runs the position division; a direct chunk also needs the
// division of the remaining count, and a start adds the limit division before
// them, while a start rejected by its input checks goes straight to S_EMIT.
// The result waits in an output register; if the receiver stalls, the
// sequencer holds the finished result until the register is free.
// Reset clears the request state, the registers to their defaults and m_tvalid.

module sector_read_chunk_planner
#(
    parameter int unsigned BOUNCE_BYTES           = srcp_pkg::DEF_BOUNCE_BYTES,
    parameter int unsigned MAX_BLOCKS_PER_COMMAND = srcp_pkg::DEF_MAX_BLOCKS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // start_sector, sector_count
    input  logic [0:0]                        s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // error_code, phys_block, block_count, bounce, skip_sectors, copy_sectors,
    // dest_sector, zero fill
    output logic [135:0]                      m_tdata,
    output logic [1:0]                        m_tuser,   // status
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [srcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srcp_pkg::REG_W-1:0]        cfg_data
);

    localparam int unsigned LW = srcp_pkg::LBA_W;
    localparam int unsigned SW = srcp_pkg::SPB_W;
    localparam logic [SW-1:0] MAX_BLK    = SW'(MAX_BLOCKS_PER_COMMAND);
    localparam logic [SW:0]   BOUNCE_SEC = (SW + 1)'(BOUNCE_BYTES / srcp_pkg::SECTOR_BYTES);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LIM_DIV  = 8'b0000_0010,
        S_POS_DIV  = 8'b0000_0100,
        S_LEFT_DIV = 8'b0000_1000,
        S_BOUNCE   = 8'b0001_0000,
        S_MUL      = 8'b0010_0000,
        S_CHUNK    = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            link_ready_reg, link_ready_next;
    logic [srcp_pkg::REG_W-1:0]      block_size_reg, block_size_next;
    logic [srcp_pkg::REG_W-1:0]      max_bulk_reg, max_bulk_next;
    logic                            active_reg, active_next;
    logic [LW-1:0]                   cur_reg, cur_next;
    logic [LW-1:0]                   left_reg, left_next;
    logic [LW-1:0]                   done_reg, done_next;
    logic [SW-1:0]                   spb_reg, spb_next;
    logic [SW-1:0]                   limit_reg, limit_next;
    logic                            m_valid_reg, m_valid_next;

    logic [LW-1:0]                   pb_reg, pb_next;
    logic [SW-1:0]                   off_reg, off_next;
    logic [SW-1:0]                   blk_reg, blk_next;
    logic [LW-1:0]                   n_reg, n_next;
    logic                            bounce_reg, bounce_next;
    srcp_pkg::result_t               res_reg, res_next;
    srcp_pkg::result_t               out_reg, out_next;

    logic                            div_start;
    logic [LW-1:0]                   div_dividend;
    logic [SW-1:0]                   div_divisor;
    logic                            div_done;
    logic [LW-1:0]                   div_quo;
    logic [SW-1:0]                   div_rem;

    logic                            accept;
    logic                            cmd;
    logic [LW-1:0]                   lba;
    logic [LW-1:0]                   cnt;
    logic [LW:0]                     range_sum;
    logic                            bs_big;
    logic [SW-1:0]                   f_calc;
    logic [SW-1:0]                   lim_capped;
    logic [SW-1:0]                   blocks_capped;
    logic [SW-1:0]                   f_minus_off;
    logic [LW-1:0]                   prod;
    logic [LW-1:0]                   left_after;

    function automatic srcp_pkg::result_t make_result(srcp_pkg::status_t st,
                                                       srcp_pkg::err_t err,
                                                       logic lst);
        srcp_pkg::result_t r;
        r              = '0;
        r.status       = st;
        r.error_code   = err;
        r.last         = lst;
        return r;
    endfunction

    srcp_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tuser[0];
    assign lba       = s_tdata[31:0];
    assign cnt       = s_tdata[63:32];
    assign range_sum = {1'b0, lba} + {1'b0, cnt};
    assign bs_big    = block_size_reg > srcp_pkg::BLOCK_SIZE_RST;
    assign f_calc    = bs_big ? block_size_reg[srcp_pkg::REG_W-1:srcp_pkg::SECTOR_SHIFT]
                              : SW'(1);
    assign lim_capped    = (div_quo[SW-1:0] > MAX_BLK) ? MAX_BLK : div_quo[SW-1:0];
    assign blocks_capped = (div_quo > {{(LW-SW){1'b0}}, limit_reg}) ? limit_reg
                                                                     : div_quo[SW-1:0];
    assign f_minus_off   = spb_reg - off_reg;
    assign prod          = {{(LW-SW){1'b0}}, blk_reg} * {{(LW-SW){1'b0}}, spb_reg};
    assign left_after    = left_reg - n_reg;

    // configuration writes
    always_comb
    begin
        link_ready_next = link_ready_reg;
        block_size_next = block_size_reg;
        max_bulk_next   = max_bulk_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                srcp_pkg::CFG_LINK_READY: link_ready_next = cfg_data[0];
                srcp_pkg::CFG_BLOCK_SIZE: block_size_next = cfg_data;
                srcp_pkg::CFG_MAX_BULK:   max_bulk_next   = cfg_data;
                default:                  link_ready_next = link_ready_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        done_next    = done_reg;
        spb_next     = spb_reg;
        limit_next   = limit_reg;
        pb_next      = pb_reg;
        off_next     = off_reg;
        blk_next     = blk_reg;
        n_next       = n_reg;
        bounce_next  = bounce_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        div_start    = 1'b0;
        div_dividend = cur_reg;
        div_divisor  = spb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd)
                    begin
                        if (!active_reg)
                        begin
                            res_next   = make_result(srcp_pkg::ST_IDLE, srcp_pkg::ERR_NONE,
                                                     1'b0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_POS_DIV;
                        end
                    end
                    else
                    begin
                        active_next = 1'b0;
                        state_next  = S_EMIT;
                        priority if (!link_ready_reg)
                            res_next = make_result(srcp_pkg::ST_ERROR, srcp_pkg::ERR_LINK,
                                                   1'b1);
                        else if (cnt == '0)
                            res_next = make_result(srcp_pkg::ST_EMPTY, srcp_pkg::ERR_NONE,
                                                   1'b1);
                        else if (range_sum > {1'b1, {LW{1'b0}}})
                            res_next = make_result(srcp_pkg::ST_ERROR, srcp_pkg::ERR_RANGE,
                                                   1'b1);
                        else if (bs_big && block_size_reg[srcp_pkg::SECTOR_SHIFT-1:0] != '0)
                            res_next = make_result(srcp_pkg::ST_ERROR,
                                                   srcp_pkg::ERR_BLOCK_SIZE, 1'b1);
                        else
                        begin
                            cur_next     = lba;
                            left_next    = cnt;
                            done_next    = '0;
                            spb_next     = f_calc;
                            div_start    = 1'b1;
                            div_dividend = {{(LW-SW){1'b0}},
                                max_bulk_reg[srcp_pkg::REG_W-1:srcp_pkg::SECTOR_SHIFT]};
                            div_divisor  = f_calc;
                            state_next   = S_LIM_DIV;
                        end
                    end
                end
            end
            S_LIM_DIV:
            begin
                if (div_done)
                begin
                    if (lim_capped == '0)
                    begin
                        res_next   = make_result(srcp_pkg::ST_ERROR, srcp_pkg::ERR_ZERO_LIMIT,
                                                 1'b1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        limit_next  = lim_capped;
                        active_next = 1'b1;
                        div_start   = 1'b1;
                        state_next  = S_POS_DIV;
                    end
                end
            end
            S_POS_DIV:
            begin
                if (div_done)
                begin
                    pb_next  = div_quo;
                    off_next = div_rem;
                    if (div_rem == '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = left_reg;
                        state_next   = S_LEFT_DIV;
                    end
                    else
                        state_next = S_BOUNCE;
                end
            end
            S_LEFT_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo != '0)
                    begin
                        blk_next   = blocks_capped;
                        state_next = S_MUL;
                    end
                    else
                        state_next = S_BOUNCE;
                end
            end
            S_BOUNCE:
            begin
                if ({1'b0, spb_reg} > BOUNCE_SEC)
                begin
                    active_next = 1'b0;
                    res_next    = make_result(srcp_pkg::ST_ERROR, srcp_pkg::ERR_BOUNCE, 1'b1);
                    state_next  = S_EMIT;
                end
                else
                begin
                    n_next      = ({{(LW-SW){1'b0}}, f_minus_off} > left_reg) ? left_reg
                                  : {{(LW-SW){1'b0}}, f_minus_off};
                    blk_next    = SW'(1);
                    bounce_next = 1'b1;
                    state_next  = S_CHUNK;
                end
            end
            S_MUL:
            begin
                n_next      = prod;
                bounce_next = 1'b0;
                state_next  = S_CHUNK;
            end
            S_CHUNK:
            begin
                res_next              = make_result(srcp_pkg::ST_CHUNK, srcp_pkg::ERR_NONE,
                                                    left_after == '0);
                res_next.phys_block   = pb_reg;
                res_next.block_count  = blk_reg;
                res_next.bounce       = bounce_reg;
                res_next.skip_sectors = bounce_reg ? off_reg[14:0] : 15'd0;
                res_next.copy_sectors = n_reg;
                res_next.dest_sector  = done_reg;
                cur_next              = cur_reg + n_reg;
                left_next             = left_after;
                done_next             = done_reg + n_reg;
                active_next           = left_after != '0;
                state_next            = S_EMIT;
            end
            S_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            link_ready_reg <= 1'b0;
            block_size_reg <= srcp_pkg::BLOCK_SIZE_RST;
            max_bulk_reg   <= srcp_pkg::MAX_BULK_RST;
            active_reg     <= 1'b0;
            cur_reg        <= '0;
            left_reg       <= '0;
            done_reg       <= '0;
            spb_reg        <= SW'(1);
            limit_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            link_ready_reg <= link_ready_next;
            block_size_reg <= block_size_next;
            max_bulk_reg   <= max_bulk_next;
            active_reg     <= active_next;
            cur_reg        <= cur_next;
            left_reg       <= left_next;
            done_reg       <= done_next;
            spb_reg        <= spb_next;
            limit_reg      <= limit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pb_reg     <= pb_next;
        off_reg    <= off_next;
        blk_reg    <= blk_next;
        n_reg      <= n_next;
        bounce_reg <= bounce_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'd0, out_reg.dest_sector, out_reg.copy_sectors, out_reg.skip_sectors,
                       out_reg.bounce, out_reg.block_count, out_reg.phys_block,
                       out_reg.error_code};

    // divider results only arrive while the sequencer waits for them
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_LIM_DIV || state_reg == S_POS_DIV ||
                      state_reg == S_LEFT_DIV))
        else $error("divider result outside a wait state");

    // an active request always has a usable geometry and limit
    a_active_geometry: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (spb_reg != '0 && limit_reg != '0))
        else $error("active request with zero factor or limit");

    // a chunk that uses up the request ends it
    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHUNK && left_after == '0) |=> !active_reg)
        else $error("request still active after its last chunk");

    // a finished result is never dropped by a new one while the receiver stalls
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(out_reg)))
        else $error("pending result overwritten");

endmodule

/* bench/tb_sector_read_chunk_planner.sv */
// testbench for sector_read_chunk_planner: directed geometry and error cases, then random
// request streams under several register settings and idling mixes, checked word by word
// depends on srcp_pkg and the planner rtl
`timescale 1ns / 1ps

module tb_sector_read_chunk_planner;

    localparam logic [srcp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam bit CMD_START = 1'b0;
    localparam bit CMD_NEXT  = 1'b1;
    localparam logic [31:0] BOUNCE_LIMIT = srcp_pkg::DEF_BOUNCE_BYTES;
    localparam logic [31:0] BLOCK_CAP    = srcp_pkg::DEF_MAX_BLOCKS;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 136;

    class chunk_plan_board;
        bit          link_up;
        logic [24:0] bsize;
        logic [24:0] bulk_max;
        bit          req_open;
        logic [31:0] next_sector;
        logic [31:0] remaining;
        logic [31:0] delivered;
        logic [31:0] factor;
        logic [31:0] limit_blocks;
        srcp_pkg::result_t planned[$];
        int errors;
        int n_start, n_direct, n_bounce, n_fail, n_empty, n_idle, n_cfg;

        function new();
            link_up = 1'b0;
            bsize = srcp_pkg::BLOCK_SIZE_RST;
            bulk_max = srcp_pkg::MAX_BULK_RST;
            req_open = 1'b0;
            next_sector = '0;
            remaining = '0;
            delivered = '0;
            factor = 32'd1;
            limit_blocks = '0;
            errors = 0;
            n_start = 0; n_direct = 0; n_bounce = 0;
            n_fail = 0; n_empty = 0; n_idle = 0; n_cfg = 0;
        endfunction

        function void set_reg(logic [srcp_pkg::CFG_IDX_W-1:0] idx,
                              logic [srcp_pkg::REG_W-1:0] val);
            n_cfg++;
            case (idx)
                srcp_pkg::CFG_LINK_READY: link_up = val[0];
                srcp_pkg::CFG_BLOCK_SIZE: bsize = val;
                srcp_pkg::CFG_MAX_BULK:   bulk_max = val;
                default: ;
            endcase
        endfunction

        function srcp_pkg::result_t abort(srcp_pkg::err_t code);
            srcp_pkg::result_t r;
            r = '0;
            req_open = 1'b0;
            r.status = srcp_pkg::ST_ERROR;
            r.error_code = code;
            r.last = 1'b1;
            n_fail++;
            return r;
        endfunction

        function srcp_pkg::result_t plan_chunk();
            srcp_pkg::result_t r;
            logic [31:0] off, pb, dest, n, blocks;
            bit bn;
            r = '0;
            off = next_sector % factor;
            pb = next_sector / factor;
            dest = delivered;
            if (off == 0 && (remaining / factor) != 0) begin
                blocks = remaining / factor;
                if (blocks > limit_blocks)
                    blocks = limit_blocks;
                n = blocks * factor;
                bn = 1'b0;
            end
            else begin
                if ({32'd0, factor} * srcp_pkg::SECTOR_BYTES > {32'd0, BOUNCE_LIMIT})
                    return abort(srcp_pkg::ERR_BOUNCE);
                n = factor - off;
                if (n > remaining)
                    n = remaining;
                blocks = 32'd1;
                bn = 1'b1;
            end
            next_sector += n;
            remaining -= n;
            delivered += n;
            if (remaining == 0)
                req_open = 1'b0;
            r.status = srcp_pkg::ST_CHUNK;
            r.error_code = srcp_pkg::ERR_NONE;
            r.phys_block = pb;
            r.block_count = blocks[15:0];
            r.bounce = bn;
            r.skip_sectors = bn ? off[14:0] : 15'd0;
            r.copy_sectors = n;
            r.dest_sector = dest;
            r.last = (remaining == 0);
            if (bn)
                n_bounce++;
            else
                n_direct++;
            return r;
        endfunction

        function void note_word(bit cmd, logic [31:0] lba, logic [31:0] cnt);
            srcp_pkg::result_t r;
            logic [31:0] f, lim;
            bit bad_size;
            r = '0;
            if (cmd == CMD_NEXT) begin
                if (!req_open) begin
                    r.status = srcp_pkg::ST_IDLE;
                    n_idle++;
                end
                else
                    r = plan_chunk();
            end
            else begin
                n_start++;
                req_open = 1'b0;
                if (!link_up)
                    r = abort(srcp_pkg::ERR_LINK);
                else if (cnt == 0) begin
                    r.status = srcp_pkg::ST_EMPTY;
                    r.last = 1'b1;
                    n_empty++;
                end
                else if (lba > 32'hFFFF_FFFF - (cnt - 1))
                    r = abort(srcp_pkg::ERR_RANGE);
                else begin
                    f = 32'd1;
                    bad_size = 1'b0;
                    if (bsize > srcp_pkg::SECTOR_BYTES) begin
                        if ((bsize % srcp_pkg::SECTOR_BYTES) != 0)
                            bad_size = 1'b1;
                        else
                            f = bsize / srcp_pkg::SECTOR_BYTES;
                    end
                    if (bad_size)
                        r = abort(srcp_pkg::ERR_BLOCK_SIZE);
                    else begin
                        lim = bulk_max / (f * srcp_pkg::SECTOR_BYTES);
                        if (lim > BLOCK_CAP)
                            lim = BLOCK_CAP;
                        if (lim == 0)
                            r = abort(srcp_pkg::ERR_ZERO_LIMIT);
                        else begin
                            req_open = 1'b1;
                            next_sector = lba;
                            remaining = cnt;
                            delivered = '0;
                            factor = f;
                            limit_blocks = lim;
                            r = plan_chunk();
                        end
                    end
                end
            end
            planned.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_word(srcp_pkg::result_t got);
            srcp_pkg::result_t want;
            if (planned.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = planned.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("error_code", got.error_code, want.error_code);
            compare_field("phys_block", got.phys_block, want.phys_block);
            compare_field("block_count", got.block_count, want.block_count);
            compare_field("bounce", got.bounce, want.bounce);
            compare_field("skip_sectors", got.skip_sectors, want.skip_sectors);
            compare_field("copy_sectors", got.copy_sectors, want.copy_sectors);
            compare_field("dest_sector", got.dest_sector, want.dest_sector);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [63:0]                    s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [135:0]                   m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_wr_en;
    logic [srcp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [srcp_pkg::REG_W-1:0]     cfg_data;

    chunk_plan_board board;
    int tx_gap_pct;
    int rx_stall_pct;
    srcp_pkg::result_t got_word;

    sector_read_chunk_planner u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver side: random stalls, check every accepted word
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.status       = srcp_pkg::status_t'(m_tuser);
            got_word.error_code   = srcp_pkg::err_t'(m_tdata[2:0]);
            got_word.phys_block   = m_tdata[34:3];
            got_word.block_count  = m_tdata[50:35];
            got_word.bounce       = m_tdata[51];
            got_word.skip_sectors = m_tdata[66:52];
            got_word.copy_sectors = m_tdata[98:67];
            got_word.dest_sector  = m_tdata[130:99];
            got_word.last         = m_tlast;
            board.check_word(got_word);
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_word(bit cmd, logic [31:0] lba, logic [31:0] cnt);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {cnt, lba};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_word(cmd, lba, cnt);
        @(negedge clk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (board.planned.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [srcp_pkg::CFG_IDX_W-1:0] idx,
                             logic [srcp_pkg::REG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.set_reg(idx, val);
    endtask

    initial
    begin
        logic [31:0] bs, mb, spb, lim, lim_few, lba, cnt, junk;
        bit link, cmd;
        int nexts_left;

        board = new();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: link down
        send_word(CMD_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_START, 32'd0, 32'd1);
        quiesce();
        write_reg(srcp_pkg::CFG_LINK_READY, 25'd1);
        // 512-byte blocks, 128-block bulk limit
        send_word(CMD_START, 32'd0, 32'd0);
        send_word(CMD_START, 32'hFFFF_FFFF, 32'd1);
        send_word(CMD_START, 32'hFFFF_FFFF, 32'd2);
        send_word(CMD_START, 32'd0, 32'hFFFF_FFFF);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_START, 32'd5, 32'd300);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        quiesce();
        // 4k blocks: bounce head, direct body, bounce tail
        write_reg(srcp_pkg::CFG_BLOCK_SIZE, 25'd4096);
        send_word(CMD_START, 32'd13, 32'd200);
        repeat (4) send_word(CMD_NEXT, 32'd0, 32'd0);
        quiesce();
        write_reg(srcp_pkg::CFG_BLOCK_SIZE, 25'd513);
        send_word(CMD_START, 32'd0, 32'd8);
        quiesce();
        // block larger than the bounce buffer
        write_reg(srcp_pkg::CFG_BLOCK_SIZE, 25'd66048);
        write_reg(srcp_pkg::CFG_MAX_BULK, 25'd16777216);
        send_word(CMD_START, 32'd1, 32'd10);
        send_word(CMD_START, 32'd0, 32'd1000);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        quiesce();
        write_reg(srcp_pkg::CFG_MAX_BULK, 25'd0);
        send_word(CMD_START, 32'd0, 32'd1);
        quiesce();
        // largest block; registers change mid-request
        write_reg(srcp_pkg::CFG_BLOCK_SIZE, 25'd16777216);
        write_reg(srcp_pkg::CFG_MAX_BULK, 25'd16777216);
        write_reg(CFG_UNUSED, 25'h1FF_FFFF);
        send_word(CMD_START, 32'd0, 32'd98304);
        quiesce();
        write_reg(srcp_pkg::CFG_LINK_READY, 25'd0);
        write_reg(srcp_pkg::CFG_BLOCK_SIZE, 25'd512);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_NEXT, 32'd0, 32'd0);
        send_word(CMD_START, 32'd0, 32'd1);
        quiesce();

        nexts_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            link = ($urandom_range(9) != 0);
            case ($urandom_range(9))
                0: bs = $urandom_range(0, 512);
                1, 2: bs = 512;
                3, 4: bs = 32'd512 << $urandom_range(1, 4);
                5: bs = 512 * $urandom_range(1, 128);
                6: bs = 512 * $urandom_range(129, 32768);
                7: bs = 512 * $urandom_range(1, 32768) + $urandom_range(1, 511);
                8: bs = 16777216;
                default: bs = 65536;
            endcase
            spb = (bs > 512) ? bs / 512 : 32'd1;
            case ($urandom_range(7))
                0: mb = $urandom_range(0, spb * 512 - 1);
                1: mb = $urandom;
                2: mb = 16777216;
                3, 4: mb = spb * 512 * $urandom_range(1, 8);
                5: mb = spb * 512 * $urandom_range(1, 64) + $urandom_range(0, 511);
                6: mb = 65536;
                default: mb = 32'h1FF_FFFF;
            endcase
            mb = mb & 32'h1FF_FFFF;
            lim = mb / (spb * 512);
            if (lim > BLOCK_CAP)
                lim = BLOCK_CAP;
            if (lim == 0)
                lim = 1;
            lim_few = (lim > 8) ? 32'd8 : lim;

            write_reg(srcp_pkg::CFG_LINK_READY, {24'd0, link});
            write_reg(srcp_pkg::CFG_BLOCK_SIZE, bs[24:0]);
            write_reg(srcp_pkg::CFG_MAX_BULK, mb[24:0]);
            if ($urandom_range(1))
            begin
                junk = $urandom;
                write_reg(CFG_UNUSED, junk[24:0]);
            end

            case (p % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 71; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
            endcase

            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    cmd = 1'($urandom_range(1));
                    lba = $urandom;
                    cnt = $urandom;
                end
                else if (nexts_left == 0)
                begin
                    cmd = CMD_START;
                    case ($urandom_range(9))
                        0: cnt = 0;
                        1: cnt = $urandom;
                        2: cnt = 32'hFFFF_FFFF;
                        3, 4, 5: cnt = $urandom_range(1, 3 * spb + 2);
                        6, 7: cnt = $urandom_range(1, 3 * spb * lim_few + spb);
                        8: cnt = spb * lim * $urandom_range(1, 3);
                        default: cnt = $urandom_range(1, 64);
                    endcase
                    case ($urandom_range(5))
                        0, 1: lba = $urandom;
                        2, 3: lba = ($urandom / spb) * spb;
                        4: lba = 32'hFFFF_FFFF - (cnt - 1) + $urandom_range(0, 1);
                        default: lba = $urandom_range(0, 4 * spb);
                    endcase
                    nexts_left = $urandom_range(0, 10);
                end
                else
                begin
                    cmd = CMD_NEXT;
                    lba = $urandom;
                    cnt = $urandom;
                    nexts_left--;
                end
                send_word(cmd, lba, cnt);
            end
            quiesce();
        end

        rx_stall_pct = 0;
        repeat (150) @(posedge clk);

        $display("covered %0d starts, %0d direct and %0d bounce chunks over %0d register writes",
                 board.n_start, board.n_direct, board.n_bounce, board.n_cfg);
        $display("with %0d error, %0d empty and %0d idle replies",
                 board.n_fail, board.n_empty, board.n_idle);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
